// File: rtl/core/tcce_pkg.sv
// Shared types, codes and constants of the text console cell engine.
package tcce_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_TAB_SIZE = 8;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [6:0]  RST_ROWS = 7'd25;
  localparam logic [7:0]  RST_COLS = 8'd80;
  localparam logic [31:0] RST_FG   = 32'h00FF_FFFF;
  localparam logic [31:0] RST_BG   = 32'h0000_0000;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_READ = 2'd1,
    OP_CLS  = 2'd2,
    OP_EOL  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_CUR_FG = 3'd2,
    REG_CUR_BG = 3'd3,
    REG_DEF_FG = 3'd4,
    REG_DEF_BG = 3'd5
  } reg_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_INIT_WRITE,
    CMD_LOAD,
    CMD_PUT_BEGIN,
    CMD_SCR_SETUP,
    CMD_SCR_READ,
    CMD_SCR_WRITE,
    CMD_BLANK_SETUP,
    CMD_CLR_SETUP,
    CMD_CLR_WRITE,
    CMD_EOL_SETUP,
    CMD_EOL_WRITE,
    CMD_CHAR,
    CMD_CR_WRITE,
    CMD_BS_READ,
    CMD_BS_CHECK,
    CMD_RD_ISSUE,
    CMD_RD_CAPTURE
  } cmd_e;

  typedef struct packed {
    op_e  op;
    logic shift;
    logic rows_one;
    logic in_range;
    logic walk_last;
    logic eol_last;
    logic init_last;
    logic cr_last;
    logic row_done;
    logic scr_last;
    logic scan_needed;
    logic cr_needed;
    logic tab_more;
    logic bs_stop;
  } status_t;

endpackage

// File: rtl/core/tcce_datapath.sv
// Datapath of the text console cell engine: cell memory, cursor, walk counters and registers.
module tcce_datapath import tcce_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int TAB_SIZE = DEF_TAB_SIZE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_e        cmd_i,
  output status_t     status_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic [5:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic        scroll_pending_o,
  output logic [7:0]  cell_char_o,
  output logic [31:0] cell_fg_o,
  output logic [31:0] cell_bg_o
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int TW    = (TAB_SIZE > 1) ? $clog2(TAB_SIZE) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TabRecip = (65536 + TAB_SIZE - 1) / TAB_SIZE;

  logic [71:0]   mem [DEPTH];
  logic [71:0]   rdata_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [71:0]   wdata;

  logic [6:0]  rows_cfg_q;
  logic [7:0]  cols_cfg_q;
  logic [31:0] cur_fg_q, cur_bg_q, def_fg_q, def_bg_q;

  op_e         op_q;
  logic [7:0]  pch_q, pch_d;
  logic [5:0]  rr_q;
  logic [6:0]  rc_q;
  logic [RW-1:0] cur_row_q, cur_row_d, wr_q, wr_d;
  logic [CW-1:0] cur_col_q, cur_col_d, wc_q, wc_d;
  logic          shift_q, shift_d;
  logic [TW-1:0] tab_q, tab_d;
  logic [7:0]    cc_q, cc_d;
  logic [31:0]   cf_q, cf_d, cb_q, cb_d;

  logic [RCW-1:0] eff_rows;
  logic [CCW-1:0] eff_cols;
  logic [7:0]     rd_code;
  int             tab_q_i;
  int             tab_r;

  function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  assign rd_code = rdata_q[71:64];

  always_comb begin
    if (rows_cfg_q == 7'd0) begin
      eff_rows = RCW'(1);
    end else if (int'(rows_cfg_q) > MAX_ROWS) begin
      eff_rows = RCW'(MAX_ROWS);
    end else begin
      eff_rows = RCW'(rows_cfg_q);
    end
    if (cols_cfg_q == 8'd0) begin
      eff_cols = CCW'(1);
    end else if (int'(cols_cfg_q) > MAX_COLS) begin
      eff_cols = CCW'(MAX_COLS);
    end else begin
      eff_cols = CCW'(cols_cfg_q);
    end
  end

  always_comb begin
    tab_q_i = (int'(cur_col_q) * TabRecip) >>> 16;
    tab_r   = int'(cur_col_q) - tab_q_i * TAB_SIZE;
    if (tab_r >= TAB_SIZE) begin
      tab_r = tab_r - TAB_SIZE;
    end
  end

  always_comb begin
    status_o.op          = op_q;
    status_o.shift       = shift_q;
    status_o.rows_one    = (int'(eff_rows) == 1);
    status_o.in_range    = (int'(rr_q) < int'(eff_rows)) && (int'(rc_q) < int'(eff_cols));
    status_o.walk_last   = (int'(wr_q) == int'(eff_rows) - 1) &&
                           (int'(wc_q) == int'(eff_cols) - 1);
    status_o.eol_last    = (int'(wc_q) == int'(eff_cols) - 1);
    status_o.init_last   = (int'(wr_q) == MAX_ROWS - 1) && (int'(wc_q) == MAX_COLS - 1);
    status_o.cr_last     = (int'(wc_q) + 1 == int'(cur_col_q));
    status_o.row_done    = (rd_code == CH_NUL) || (int'(wc_q) == int'(eff_cols) - 1);
    status_o.scr_last    = (int'(wr_q) + 2 == int'(eff_rows));
    status_o.scan_needed = (pch_q == CH_BS) && (cur_col_q == '0) && (cur_row_q != '0);
    status_o.cr_needed   = (pch_q == CH_CR) && (cur_col_q != '0);
    status_o.tab_more    = (tab_q != '0);
    status_o.bs_stop     = (cur_col_q == '0) || (rd_code != CH_NUL);
  end

  always_comb begin
    pch_d     = pch_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    wr_d      = wr_q;
    wc_d      = wc_q;
    shift_d   = shift_q;
    tab_d     = tab_q;
    cc_d      = cc_q;
    cf_d      = cf_q;
    cb_d      = cb_q;
    we        = 1'b0;
    waddr     = cell_addr(cur_row_q, cur_col_q);
    wdata     = {CH_SPACE, def_fg_q, def_bg_q};
    raddr     = cell_addr(cur_row_q, cur_col_q);
    case (cmd_i)
      CMD_INIT_WRITE: begin
        we    = 1'b1;
        waddr = cell_addr(wr_q, wc_q);
        wdata = {(wc_q == '0) ? CH_NL : CH_NUL, RST_FG, RST_BG};
        if (int'(wc_q) == MAX_COLS - 1) begin
          wc_d = '0;
          wr_d = (int'(wr_q) == MAX_ROWS - 1) ? '0 : RW'(int'(wr_q) + 1);
        end else begin
          wc_d = CW'(int'(wc_q) + 1);
        end
      end
      CMD_LOAD: begin
        cc_d = '0;
        cf_d = '0;
        cb_d = '0;
        if (int'(cur_row_q) >= int'(eff_rows)) begin
          cur_row_d = RW'(int'(eff_rows) - 1);
        end
        if (int'(cur_col_q) >= int'(eff_cols)) begin
          cur_col_d = CW'(int'(eff_cols) - 1);
        end
      end
      CMD_PUT_BEGIN: begin
        if (pch_q == CH_TAB) begin
          pch_d = CH_SPACE;
          tab_d = TW'(TAB_SIZE - tab_r - 1);
        end else begin
          tab_d = '0;
        end
      end
      CMD_SCR_SETUP: begin
        wr_d = '0;
        wc_d = '0;
      end
      CMD_SCR_READ: begin
        raddr = cell_addr(RW'(int'(wr_q) + 1), wc_q);
      end
      CMD_SCR_WRITE: begin
        we    = 1'b1;
        waddr = cell_addr(wr_q, wc_q);
        wdata = rdata_q;
        if (status_o.row_done) begin
          wc_d = '0;
          wr_d = RW'(int'(wr_q) + 1);
        end else begin
          wc_d = CW'(int'(wc_q) + 1);
        end
      end
      CMD_BLANK_SETUP: begin
        wr_d    = RW'(int'(eff_rows) - 1);
        wc_d    = '0;
        shift_d = 1'b0;
      end
      CMD_CLR_SETUP: begin
        wr_d      = '0;
        wc_d      = '0;
        cur_row_d = '0;
        cur_col_d = '0;
      end
      CMD_CLR_WRITE: begin
        we    = 1'b1;
        waddr = cell_addr(wr_q, wc_q);
        wdata = {(wc_q == '0) ? CH_NL : CH_NUL, def_fg_q, def_bg_q};
        if (int'(wc_q) == int'(eff_cols) - 1) begin
          wc_d = '0;
          wr_d = RW'(int'(wr_q) + 1);
        end else begin
          wc_d = CW'(int'(wc_q) + 1);
        end
      end
      CMD_EOL_SETUP: begin
        wr_d = cur_row_q;
        wc_d = cur_col_q;
      end
      CMD_EOL_WRITE: begin
        we    = 1'b1;
        waddr = cell_addr(wr_q, wc_q);
        wdata = {(wc_q == cur_col_q) ? CH_NL : CH_NUL, def_fg_q, def_bg_q};
        wc_d  = CW'(int'(wc_q) + 1);
      end
      CMD_CHAR: begin
        if (tab_q != '0) begin
          tab_d = TW'(int'(tab_q) - 1);
        end
        case (pch_q)
          CH_NL: begin
            we        = 1'b1;
            wdata     = {CH_NL, def_fg_q, def_bg_q};
            cur_col_d = '0;
            if (int'(cur_row_q) + 1 < int'(eff_rows)) begin
              cur_row_d = RW'(int'(cur_row_q) + 1);
            end else begin
              shift_d = 1'b1;
            end
          end
          CH_BS: begin
            if (cur_col_q != '0) begin
              cur_col_d = CW'(int'(cur_col_q) - 1);
              we        = 1'b1;
              waddr     = cell_addr(cur_row_q, CW'(int'(cur_col_q) - 1));
            end else if (cur_row_q != '0) begin
              cur_row_d = RW'(int'(cur_row_q) - 1);
              cur_col_d = CW'(int'(eff_cols) - 1);
            end else begin
              we = 1'b1;
            end
          end
          CH_CR: begin
            wc_d = '0;
          end
          default: begin
            we    = 1'b1;
            wdata = {pch_q, cur_fg_q, cur_bg_q};
            if (int'(cur_col_q) + 1 >= int'(eff_cols)) begin
              cur_col_d = '0;
              if (int'(cur_row_q) + 1 < int'(eff_rows)) begin
                cur_row_d = RW'(int'(cur_row_q) + 1);
              end else begin
                shift_d = 1'b1;
              end
            end else begin
              cur_col_d = CW'(int'(cur_col_q) + 1);
            end
          end
        endcase
      end
      CMD_CR_WRITE: begin
        we    = 1'b1;
        waddr = cell_addr(cur_row_q, wc_q);
        wdata = {CH_SPACE, cur_fg_q, cur_bg_q};
        wc_d  = CW'(int'(wc_q) + 1);
        if (status_o.cr_last) begin
          cur_col_d = '0;
        end
      end
      CMD_BS_READ: begin
        raddr = cell_addr(cur_row_q, cur_col_q);
      end
      CMD_BS_CHECK: begin
        if (status_o.bs_stop) begin
          we = 1'b1;
        end else begin
          cur_col_d = CW'(int'(cur_col_q) - 1);
        end
      end
      CMD_RD_ISSUE: begin
        raddr = cell_addr(RW'(rr_q), CW'(rc_q));
      end
      CMD_RD_CAPTURE: begin
        cc_d = rdata_q[71:64];
        cf_d = rdata_q[63:32];
        cb_d = rdata_q[31:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      op_q  <= op_e'(opcode_i);
      pch_q <= char_code_i;
      rr_q  <= read_row_i;
      rc_q  <= read_col_i;
    end else begin
      pch_q <= pch_d;
    end
    cc_q <= cc_d;
    cf_q <= cf_d;
    cb_q <= cb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      wr_q       <= '0;
      wc_q       <= '0;
      shift_q    <= 1'b0;
      tab_q      <= '0;
      rows_cfg_q <= RST_ROWS;
      cols_cfg_q <= RST_COLS;
      cur_fg_q   <= RST_FG;
      cur_bg_q   <= RST_BG;
      def_fg_q   <= RST_FG;
      def_bg_q   <= RST_BG;
    end else begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      wr_q      <= wr_d;
      wc_q      <= wc_d;
      shift_q   <= shift_d;
      tab_q     <= tab_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ROWS:   rows_cfg_q <= cfg_data_i[6:0];
          REG_COLS:   cols_cfg_q <= cfg_data_i[7:0];
          REG_CUR_FG: cur_fg_q   <= cfg_data_i;
          REG_CUR_BG: cur_bg_q   <= cfg_data_i;
          REG_DEF_FG: def_fg_q   <= cfg_data_i;
          REG_DEF_BG: def_bg_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  assign cursor_row_o     = 6'(cur_row_q);
  assign cursor_col_o     = 7'(cur_col_q);
  assign scroll_pending_o = shift_q;
  assign cell_char_o      = cc_q;
  assign cell_fg_o        = cf_q;
  assign cell_bg_o        = cb_q;

endmodule

// File: rtl/core/tcce_controller.sv
// Sequencing state machine of the text console cell engine.
module tcce_controller import tcce_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_e    cmd_o
);

  typedef enum logic [16:0] {
    S_INIT     = 17'h00001,
    S_IDLE     = 17'h00002,
    S_DISPATCH = 17'h00004,
    S_PUT      = 17'h00008,
    S_SCR_SET  = 17'h00010,
    S_SCR_RD   = 17'h00020,
    S_SCR_WR   = 17'h00040,
    S_BLANK    = 17'h00080,
    S_BLANK_WR = 17'h00100,
    S_CHAR     = 17'h00200,
    S_CR_WR    = 17'h00400,
    S_BS_RD    = 17'h00800,
    S_BS_CK    = 17'h01000,
    S_RD_CAP   = 17'h02000,
    S_CLR_WR   = 17'h04000,
    S_EOL_WR   = 17'h08000,
    S_RESP     = 17'h10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_INIT: begin
        cmd_o = CMD_INIT_WRITE;
        if (status_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.op)
          OP_PUT: begin
            cmd_o   = CMD_PUT_BEGIN;
            state_d = S_PUT;
          end
          OP_READ: begin
            cmd_o   = CMD_RD_ISSUE;
            state_d = status_i.in_range ? S_RD_CAP : S_RESP;
          end
          OP_CLS: begin
            cmd_o   = CMD_CLR_SETUP;
            state_d = S_CLR_WR;
          end
          default: begin
            cmd_o   = CMD_EOL_SETUP;
            state_d = S_EOL_WR;
          end
        endcase
      end
      S_PUT: begin
        state_d = status_i.shift ? S_SCR_SET : S_CHAR;
      end
      S_SCR_SET: begin
        cmd_o   = CMD_SCR_SETUP;
        state_d = status_i.rows_one ? S_BLANK : S_SCR_RD;
      end
      S_SCR_RD: begin
        cmd_o   = CMD_SCR_READ;
        state_d = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd_o   = CMD_SCR_WRITE;
        state_d = (status_i.row_done && status_i.scr_last) ? S_BLANK : S_SCR_RD;
      end
      S_BLANK: begin
        cmd_o   = CMD_BLANK_SETUP;
        state_d = S_BLANK_WR;
      end
      S_BLANK_WR: begin
        cmd_o = CMD_CLR_WRITE;
        if (status_i.walk_last) state_d = S_CHAR;
      end
      S_CHAR: begin
        cmd_o = CMD_CHAR;
        if (status_i.scan_needed) begin
          state_d = S_BS_RD;
        end else if (status_i.cr_needed) begin
          state_d = S_CR_WR;
        end else if (status_i.tab_more) begin
          state_d = S_PUT;
        end else begin
          state_d = S_RESP;
        end
      end
      S_CR_WR: begin
        cmd_o = CMD_CR_WRITE;
        if (status_i.cr_last) state_d = S_RESP;
      end
      S_BS_RD: begin
        cmd_o   = CMD_BS_READ;
        state_d = S_BS_CK;
      end
      S_BS_CK: begin
        cmd_o   = CMD_BS_CHECK;
        state_d = status_i.bs_stop ? S_RESP : S_BS_RD;
      end
      S_RD_CAP: begin
        cmd_o   = CMD_RD_CAPTURE;
        state_d = S_RESP;
      end
      S_CLR_WR: begin
        cmd_o = CMD_CLR_WRITE;
        if (status_i.walk_last) state_d = S_RESP;
      end
      S_EOL_WR: begin
        cmd_o = CMD_EOL_WRITE;
        if (status_i.eol_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output handshakes both open");
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISPATCH))
    else $error("accepted transaction not dispatched");
  a_resp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o)
    else $error("not ready after result transaction");

endmodule

// File: rtl/core/text_console_cell_engine.sv
// Top level of the text console cell engine.
// One operation is in flight at a time, and the next transaction is taken in the cycle after the
// result is accepted. A put of an ordinary character, newline, return at column 0 or plain
// backspace passes the dispatch, put and character states. A read inside the grid passes the
// dispatch and capture states; one outside goes straight to the result. Longer operations walk
// the cell memory through its single write port and registered read port. A tab repeats the put
// and character states per extra space. A waiting scroll adds the scroll setup state, a read and
// a write state per cell copied, the blank setup state and a write state per cell of the blanked
// row. A return adds a write state per cell filled, and a backspace that scans the row above
// adds a read and a check state per cell examined. Clear screen and clear to end of line add a
// write state per cell. After reset all MAX_ROWS * MAX_COLS cells (8192 by default) are swept
// once before the first transaction is taken; configuration writes are accepted at any time.
module text_console_cell_engine import tcce_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int TAB_SIZE = DEF_TAB_SIZE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic        scroll_pending_o,
  output logic [7:0]  cell_char_o,
  output logic [31:0] cell_fg_o,
  output logic [31:0] cell_bg_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cmd_e    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  tcce_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcce_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .TAB_SIZE (TAB_SIZE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .opcode_i         (opcode_i),
    .char_code_i      (char_code_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cursor_row_o     (cursor_row_o),
    .cursor_col_o     (cursor_col_o),
    .scroll_pending_o (scroll_pending_o),
    .cell_char_o      (cell_char_o),
    .cell_fg_o        (cell_fg_o),
    .cell_bg_o        (cell_bg_o)
  );

endmodule

// File: tb/text_console_cell_engine_checker.sv
// Checker for the text console cell engine: predicts every result and compares it.
`timescale 1ns / 1ps

module text_console_cell_engine_checker import tcce_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int TAB_SIZE = DEF_TAB_SIZE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [5:0]  cursor_row_i,
  input  logic [6:0]  cursor_col_i,
  input  logic        scroll_pending_i,
  input  logic [7:0]  cell_char_i,
  input  logic [31:0] cell_fg_i,
  input  logic [31:0] cell_bg_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [5:0]  row;
    logic [6:0]  col;
    logic        pend;
    logic [7:0]  code;
    logic [31:0] fg;
    logic [31:0] bg;
  } console_result_t;

  console_result_t expected_q[$];

  logic [7:0]  codes [MAX_ROWS * MAX_COLS];
  logic [31:0] fgs [MAX_ROWS * MAX_COLS];
  logic [31:0] bgs [MAX_ROWS * MAX_COLS];
  logic [6:0]  rows_reg;
  logic [7:0]  cols_reg;
  logic [31:0] cur_fg, cur_bg, def_fg, def_bg;
  int          crow, ccol;
  logic        shift;

  function automatic int num_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic int num_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int idx(int r, int c);
    return (r % MAX_ROWS) * MAX_COLS + (c % MAX_COLS);
  endfunction

  function automatic void write_cell(int r, int c, logic [7:0] code, logic [31:0] f,
                                     logic [31:0] b);
    codes[idx(r, c)] = code;
    fgs[idx(r, c)] = f;
    bgs[idx(r, c)] = b;
  endfunction

  function automatic void blank_line(int r, int n);
    write_cell(r, 0, CH_NL, def_fg, def_bg);
    for (int c = 1; c < n; c++) write_cell(r, c, CH_NUL, def_fg, def_bg);
  endfunction

  function automatic void shift_up();
    int d;
    int s;
    for (int r = 0; r + 1 < num_rows(); r++) begin
      for (int c = 0; c < num_cols(); c++) begin
        d = idx(r, c);
        s = idx(r + 1, c);
        codes[d] = codes[s];
        fgs[d] = fgs[s];
        bgs[d] = bgs[s];
        if (codes[s] == CH_NUL) break;
      end
    end
    blank_line(num_rows() - 1, num_cols());
  endfunction

  function automatic void next_row();
    if (crow + 1 < num_rows()) crow++;
    else shift = 1'b1;
  endfunction

  function automatic void put_glyph(logic [7:0] ch);
    if (shift) begin
      shift_up();
      shift = 1'b0;
    end
    case (ch)
      CH_NL: begin
        write_cell(crow, ccol, CH_NL, def_fg, def_bg);
        next_row();
        ccol = 0;
      end
      CH_TAB: begin
        for (int k = TAB_SIZE - (ccol % TAB_SIZE); k > 0; k--) put_glyph(CH_SPACE);
      end
      CH_BS: begin
        if (ccol > 0) begin
          ccol--;
        end else if (crow > 0) begin
          crow--;
          ccol = num_cols() - 1;
          while (ccol > 0 && codes[idx(crow, ccol)] == CH_NUL) ccol--;
        end
        write_cell(crow, ccol, CH_SPACE, def_fg, def_bg);
      end
      CH_CR: begin
        for (int k = 0; k < ccol; k++) write_cell(crow, k, CH_SPACE, cur_fg, cur_bg);
        ccol = 0;
      end
      default: begin
        write_cell(crow, ccol, ch, cur_fg, cur_bg);
        ccol++;
        if (ccol >= num_cols()) begin
          ccol = 0;
          next_row();
        end
      end
    endcase
  endfunction

  function automatic console_result_t apply_op(op_e op, logic [7:0] ch, int rr, int rc);
    console_result_t res;
    res.code = '0;
    res.fg = '0;
    res.bg = '0;
    if (crow >= num_rows()) crow = num_rows() - 1;
    if (ccol >= num_cols()) ccol = num_cols() - 1;
    case (op)
      OP_PUT: put_glyph(ch);
      OP_READ: begin
        if (rr < num_rows() && rc < num_cols()) begin
          res.code = codes[idx(rr, rc)];
          res.fg = fgs[idx(rr, rc)];
          res.bg = bgs[idx(rr, rc)];
        end
      end
      OP_CLS: begin
        crow = 0;
        ccol = 0;
        for (int k = 0; k < num_rows(); k++) blank_line(k, num_cols());
      end
      default: begin
        write_cell(crow, ccol, CH_NL, def_fg, def_bg);
        for (int k = ccol + 1; k < num_cols(); k++) write_cell(crow, k, CH_NUL, def_fg, def_bg);
      end
    endcase
    res.row = crow[5:0];
    res.col = ccol[6:0];
    res.pend = shift;
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    console_result_t exp_res;
    console_result_t got_res;
    if (!rst_ni) begin
      rows_reg = RST_ROWS;
      cols_reg = RST_COLS;
      cur_fg = RST_FG;
      cur_bg = RST_BG;
      def_fg = RST_FG;
      def_bg = RST_BG;
      for (int r = 0; r < MAX_ROWS; r++) blank_line(r, MAX_COLS);
      crow = 0;
      ccol = 0;
      shift = 1'b0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_ROWS:   rows_reg = cfg_data_i[6:0];
          REG_COLS:   cols_reg = cfg_data_i[7:0];
          REG_CUR_FG: cur_fg = cfg_data_i;
          REG_CUR_BG: cur_bg = cfg_data_i;
          REG_DEF_FG: def_fg = cfg_data_i;
          REG_DEF_BG: def_bg = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result, cursor row", 32'(cursor_row_i), 32'd0);
        end else begin
          exp_res = expected_q.pop_front();
          if (cursor_row_i !== exp_res.row)
            report("cursor_row", 32'(cursor_row_i), 32'(exp_res.row));
          if (cursor_col_i !== exp_res.col)
            report("cursor_col", 32'(cursor_col_i), 32'(exp_res.col));
          if (scroll_pending_i !== exp_res.pend)
            report("scroll_pending", 32'(scroll_pending_i), 32'(exp_res.pend));
          if (cell_char_i !== exp_res.code)
            report("cell_char", 32'(cell_char_i), 32'(exp_res.code));
          if (cell_fg_i !== exp_res.fg) report("cell_fg", cell_fg_i, exp_res.fg);
          if (cell_bg_i !== exp_res.bg) report("cell_bg", cell_bg_i, exp_res.bg);
        end
      end
      if (in_valid_i && in_ready_i) begin
        got_res = apply_op(op_e'(opcode_i), char_code_i, int'(read_row_i), int'(read_col_i));
        expected_q.push_back(got_res);
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// File: tb/text_console_cell_engine_tb.sv
// Top of the text console cell engine testbench: stimulus, reset, clock and verdict.
`timescale 1ns / 1ps

module text_console_cell_engine_tb;
  import tcce_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [7:0]  char_code_i = '0;
  logic [5:0]  read_row_i = '0;
  logic [6:0]  read_col_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  cursor_row_o;
  logic [6:0]  cursor_col_o;
  logic        scroll_pending_o;
  logic [7:0]  cell_char_o;
  logic [31:0] cell_fg_o;
  logic [31:0] cell_bg_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          tx_idle_pct = 11;
  int          rx_idle_pct = 55;
  int          grid_rows = 25;
  int          grid_cols = 80;

  text_console_cell_engine u_top (.*);

  text_console_cell_engine_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .char_code_i, .read_row_i, .read_col_i,
    .out_valid_i(out_valid_o), .out_ready_i, .cursor_row_i(cursor_row_o),
    .cursor_col_i(cursor_col_o), .scroll_pending_i(scroll_pending_o),
    .cell_char_i(cell_char_o), .cell_fg_i(cell_fg_o), .cell_bg_i(cell_bg_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_op(op_e op, logic [7:0] ch, logic [5:0] rr, logic [6:0] rc);
    @(negedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    char_code_i <= ch;
    read_row_i <= rr;
    read_col_i <= rc;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic put(logic [7:0] ch);
    send_op(OP_PUT, ch, 6'($urandom), 7'($urandom));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(int rows, int cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    grid_rows = (rows == 0) ? 1 : (rows > 64) ? 64 : rows;
    grid_cols = (cols == 0) ? 1 : (cols > 128) ? 128 : cols;
  endtask

  function automatic logic [31:0] pick_colour();
    case ($urandom_range(3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 10) return CH_NL;
    if (r < 16) return CH_TAB;
    if (r < 24) return CH_BS;
    if (r < 30) return CH_CR;
    if (r < 40) return 8'($urandom_range(255));
    return 8'($urandom_range(32, 126));
  endfunction

  initial begin
    int r;
    int rows;
    int cols;
    logic [5:0] rr;
    logic [6:0] rc;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    put("H");
    put("i");
    put(CH_NL);
    put(CH_BS);
    put(CH_TAB);
    put(CH_BS);
    put(CH_CR);
    put(8'hFF);
    put(CH_NUL);
    send_op(OP_READ, 8'h00, 6'd0, 7'd0);
    send_op(OP_READ, 8'hFF, 6'd0, 7'd1);
    send_op(OP_READ, 8'h00, 6'd63, 7'd127);
    send_op(OP_EOL, 8'h00, 6'd0, 7'd0);
    send_op(OP_CLS, 8'h00, 6'd0, 7'd0);
    put(CH_BS);
    drain();
    set_grid(2, 3);
    write_reg(REG_CUR_FG, 32'hFFFF_FFFF);
    write_reg(REG_DEF_BG, 32'hFFFF_FFFF);
    repeat (7) put("a");
    send_op(OP_READ, 8'h00, 6'd1, 7'd2);
    drain();
    set_grid(1, 1);
    put("x");
    put(CH_NL);
    put("y");
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      if (phase < 4) begin
        tx_idle_pct = 11;
        rx_idle_pct = 55;
      end else if (phase < 7) begin
        tx_idle_pct = 55;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      r = $urandom_range(9);
      rows = (r == 0) ? 0 : (r == 1) ? 127 : (r == 2) ? 64 : (r == 3) ? 1
             : $urandom_range(2, 6);
      r = $urandom_range(9);
      cols = (r == 0) ? 0 : (r == 1) ? 255 : (r == 2) ? 128 : (r == 3) ? 1
             : $urandom_range(2, 12);
      set_grid(rows, cols);
      write_reg(REG_CUR_FG, pick_colour());
      write_reg(REG_CUR_BG, pick_colour());
      write_reg(REG_DEF_FG, pick_colour());
      write_reg(REG_DEF_BG, pick_colour());
      for (int n = 0; n < 55; n++) begin
        r = $urandom_range(99);
        if ($urandom_range(4) == 0) begin
          rr = 6'($urandom);
          rc = 7'($urandom);
        end else begin
          rr = 6'($urandom_range(grid_rows - 1));
          rc = 7'($urandom_range(grid_cols - 1));
        end
        if (r < 70) send_op(OP_PUT, pick_char(), 6'($urandom), 7'($urandom));
        else if (r < 87) send_op(OP_READ, 8'($urandom), rr, rc);
        else if (r < 91) send_op(OP_CLS, 8'($urandom), 6'($urandom), 7'($urandom));
        else send_op(OP_EOL, 8'($urandom), 6'($urandom), 7'($urandom));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tcce_pkg.sv
rtl/core/tcce_datapath.sv
rtl/core/tcce_controller.sv
rtl/core/text_console_cell_engine.sv
tb/text_console_cell_engine_checker.sv
tb/text_console_cell_engine_tb.sv
